### design/tcfc_pkg.sv
// ----------------------------------------------------------------------------
// tcfc_pkg
// Shared constants, types and helpers for the timing command frame checker.
// ----------------------------------------------------------------------------
package tcfc_pkg;

  localparam int BYTE_W    = 8;
  localparam int TIME_W    = 7;
  localparam int POS_W     = 3;
  localparam int FRAME_LEN = 6;
  localparam int HELD_LEN  = FRAME_LEN - 1;
  localparam int TIME_BYTES = 4;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [BYTE_W-1:0] STX_BYTE   = 8'd2;
  localparam logic [BYTE_W-1:0] ETX_BYTE   = 8'd3;
  localparam logic [BYTE_W-1:0] ACK_CODE   = 8'd6;
  localparam logic [BYTE_W-1:0] NACK_CODE  = 8'd21;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  localparam logic [TIME_W-1:0] RST_MIN_TIME = 7'd10;
  localparam logic [TIME_W-1:0] RST_MAX_TIME = 7'd20;

  localparam logic [REG_IDX_W-1:0] REG_NS_MIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NS_MAX = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EW_MIN = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_EW_MAX = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] ns_min;
    logic [TIME_W-1:0] ns_max;
    logic [TIME_W-1:0] ew_min;
    logic [TIME_W-1:0] ew_max;
  } cfg_t;

  typedef struct packed {
    logic                                shape_ok;
    logic [TIME_BYTES-1:0][BYTE_W-1:0] time_bytes;
  } frame_t;

  typedef struct packed {
    logic [TIME_W-1:0] ew_green_time;
    logic [TIME_W-1:0] ns_green_time;
    logic              accepted;
    logic [BYTE_W-1:0] reply_code;
  } result_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  function automatic logic [TIME_W-1:0] digit_pair(input logic [BYTE_W-1:0] hi,
                                                   input logic [BYTE_W-1:0] lo);
    logic [TIME_W-1:0] h;
    logic [TIME_W-1:0] l;
    h = {3'b000, hi[3:0]};
    l = {3'b000, lo[3:0]};
    return (h << 3) + (h << 1) + l;
  endfunction

endpackage

### design/tcfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcfc_cfg_regs
// APB register file holding the green time limits.
// ----------------------------------------------------------------------------
module tcfc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcfc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tcfc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tcfc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output tcfc_pkg::cfg_t                cfg
);
  import tcfc_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [TIME_W-1:0]    rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_NS_MIN: cfg_nxt.ns_min = pwdata[TIME_W-1:0];
        REG_NS_MAX: cfg_nxt.ns_max = pwdata[TIME_W-1:0];
        REG_EW_MIN: cfg_nxt.ew_min = pwdata[TIME_W-1:0];
        REG_EW_MAX: cfg_nxt.ew_max = pwdata[TIME_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ns_min <= RST_MIN_TIME;
      cfg_r.ns_max <= RST_MAX_TIME;
      cfg_r.ew_min <= RST_MIN_TIME;
      cfg_r.ew_max <= RST_MAX_TIME;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NS_MIN: rd_val = cfg_r.ns_min;
      REG_NS_MAX: rd_val = cfg_r.ns_max;
      REG_EW_MIN: rd_val = cfg_r.ew_min;
      REG_EW_MAX: rd_val = cfg_r.ew_max;
      default:    rd_val = '0;
    endcase
  end

  assign prdata = {{(PDATA_W-TIME_W){1'b0}}, rd_val};
  assign cfg    = cfg_r;

endmodule

### design/tcfc_frame.sv
// ----------------------------------------------------------------------------
// tcfc_frame
// Frame assembler: tracks the byte position, holds the frame bytes and
// registers one closed-frame record per frame.
// ----------------------------------------------------------------------------
module tcfc_frame (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [tcfc_pkg::BYTE_W-1:0]  in_byte,
  output logic                         in_ready,
  output logic                         frm_vld,
  output tcfc_pkg::frame_t             frm,
  input  logic                         frm_take
);
  import tcfc_pkg::*;

  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [BYTE_W-1:0] bytes_r   [HELD_LEN];
  logic [BYTE_W-1:0] bytes_nxt [HELD_LEN];
  logic              frm_vld_r;
  logic              frm_vld_nxt;
  frame_t            frm_r;
  frame_t            frm_nxt;
  logic              accept;
  logic [POS_W-1:0]  pos_start;
  logic [POS_W-1:0]  pos_next;
  logic              closing;

  assign in_ready  = !frm_vld_r || frm_take;
  assign accept    = in_valid && in_ready;
  assign pos_start = ((in_byte == STX_BYTE) || (pos_r == '0)) ? '0 : pos_r;
  assign pos_next  = pos_start + POS_W'(1);
  assign closing   = (in_byte == ETX_BYTE) || (pos_next == POS_W'(FRAME_LEN));

  always_comb begin
    for (int i = 0; i < HELD_LEN; i++) begin
      bytes_nxt[i] = bytes_r[i];
      if (accept && (pos_start == POS_W'(i))) begin
        bytes_nxt[i] = in_byte;
      end
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = closing ? '0 : pos_next;
    end
  end

  always_comb begin
    frm_nxt          = frm_r;
    frm_vld_nxt      = frm_vld_r;
    if (frm_take) begin
      frm_vld_nxt = 1'b0;
    end
    if (accept && closing) begin
      frm_vld_nxt      = 1'b1;
      frm_nxt.shape_ok = (pos_next == POS_W'(FRAME_LEN)) && (in_byte == ETX_BYTE)
                         && (bytes_r[0] == STX_BYTE);
      for (int k = 0; k < TIME_BYTES; k++) begin
        frm_nxt.time_bytes[k] = bytes_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      frm_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      frm_vld_r <= frm_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    frm_r   <= frm_nxt;
  end

  assign frm_vld = frm_vld_r;
  assign frm     = frm_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(HELD_LEN))
    else $error("frame position out of range");

  a_etx_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_byte == ETX_BYTE) |=> frm_vld_r)
    else $error("ETX did not close the frame");

  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    frm_vld_r && !frm_take |=> frm_vld_r && $stable(frm_r))
    else $error("closed-frame record lost before transfer");

endmodule

### design/tcfc_check.sv
// ----------------------------------------------------------------------------
// tcfc_check
// Frame checker: decodes both time fields, checks their ranges and
// registers the reply.
// ----------------------------------------------------------------------------
module tcfc_check (
  input  logic               clk,
  input  logic               rst_n,
  input  tcfc_pkg::cfg_t     cfg,
  input  logic               frm_vld,
  input  tcfc_pkg::frame_t   frm,
  output logic               frm_take,
  output logic               out_valid,
  output tcfc_pkg::result_t  out_res,
  input  logic               out_ready
);
  import tcfc_pkg::*;

  logic              out_vld_r;
  logic              out_vld_nxt;
  result_t           res_r;
  result_t           res_nxt;
  logic [TIME_W-1:0] ns_val;
  logic [TIME_W-1:0] ew_val;
  logic              ns_ok;
  logic              ew_ok;
  logic              ok;

  assign frm_take = frm_vld && (!out_vld_r || out_ready);

  assign ns_val = digit_pair(frm.time_bytes[0], frm.time_bytes[1]);
  assign ew_val = digit_pair(frm.time_bytes[2], frm.time_bytes[3]);
  assign ns_ok  = is_digit(frm.time_bytes[0]) && is_digit(frm.time_bytes[1])
                  && (ns_val >= cfg.ns_min) && (ns_val <= cfg.ns_max);
  assign ew_ok  = is_digit(frm.time_bytes[2]) && is_digit(frm.time_bytes[3])
                  && (ew_val >= cfg.ew_min) && (ew_val <= cfg.ew_max);
  assign ok     = frm.shape_ok && ns_ok && ew_ok;

  always_comb begin
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (frm_take) begin
      out_vld_nxt           = 1'b1;
      res_nxt.reply_code    = ok ? ACK_CODE : NACK_CODE;
      res_nxt.accepted      = ok;
      res_nxt.ns_green_time = ok ? ns_val : '0;
      res_nxt.ew_green_time = ok ? ew_val : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = res_r;

  a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.accepted ? (res_r.reply_code == ACK_CODE)
                                  : (res_r.reply_code == NACK_CODE)))
    else $error("reply code disagrees with accepted flag");

  a_nack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.accepted |-> (res_r.ns_green_time == '0)
                                     && (res_r.ew_green_time == '0))
    else $error("rejected frame carries green times");

  a_ack_range: assert property (@(posedge clk) disable iff (!rst_n)
    frm_take && ok |=> (res_r.ns_green_time >= $past(cfg.ns_min))
                       && (res_r.ns_green_time <= $past(cfg.ns_max)))
    else $error("accepted north-south time outside limits");

endmodule

### design/timing_command_frame_checker_top.sv
// ----------------------------------------------------------------------------
// timing_command_frame_checker_top
// Assembles six-byte timing command frames from received bytes and answers
// each closed frame with ACK plus both green times, or NACK.
//
//   Channel  Dir  Payload
//   in_      in   tdata[7:0] rx_byte
//   out_     out  tdata[7:0] reply_code, [8] accepted, [15:9] ns_green_time,
//                 [22:16] ew_green_time, [23] zero
//   cfg      in   APB, regs at 0x0 ns_min, 0x4 ns_max, 0x8 ew_min, 0xC ew_max
//
// One byte per cycle while in_tready is high.
// Two registered stages (frame record, reply register) each hold while the
// next stage stalls; in_tready drops only when both are full.
// Reset is synchronous, clears position and valid flags and loads the default limits.
// ----------------------------------------------------------------------------
module timing_command_frame_checker_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tcfc_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] reply_code, [8] accepted, [15:9] ns_green_time, [22:16] ew_green_time
  output logic [tcfc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcfc_pkg::PADDR_W-1:0]       paddr,
  input  logic [tcfc_pkg::PDATA_W-1:0]       pwdata,
  output logic [tcfc_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import tcfc_pkg::*;

  cfg_t    cfg;
  logic    frm_vld;
  frame_t  frm;
  logic    frm_take;
  result_t res;

  tcfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcfc_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata[BYTE_W-1:0]),
    .in_ready (in_tready),
    .frm_vld  (frm_vld),
    .frm      (frm),
    .frm_take (frm_take)
  );

  tcfc_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .frm_vld   (frm_vld),
    .frm       (frm),
    .frm_take  (frm_take),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_ready (out_tready)
  );

  assign out_tdata = {1'b0, res};

endmodule
